FILE: hdl/tps_pkg.sv
// Package for the tournament parent selector: item types, control structs,
// state codes and fixed sizes. No dependencies; every other file depends on it.
package tps_pkg;

  // Table depth and field widths
  localparam int MAX_POP   = 256;
  localparam int IDX_BITS  = $clog2(MAX_POP);
  localparam int FIT_BITS  = 16;
  localparam int CNT_BITS  = IDX_BITS + 1;
  localparam int CFG_BITS  = 9;
  localparam int CFGA_BITS = 1;

  // Register indexes on the configuration port
  localparam logic [CFGA_BITS-1:0] CFG_POPULATION = 1'b0;
  localparam logic [CFGA_BITS-1:0] CFG_TOURN_SIZE = 1'b1;

  // Item mode codes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  // Input beat payload
  typedef struct packed {
    logic                mode;
    logic [IDX_BITS-1:0] entry_index;
    logic [FIT_BITS-1:0] fitness_value;
  } item_t;

  // Result beat payload
  typedef struct packed {
    logic [IDX_BITS-1:0] winner_index;
    logic                winner_found;
    logic [FIT_BITS-1:0] winner_fitness;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic load_we;   // write the table entry of the current beat
    logic draw_go;   // take the current draw: mark seen, start table read
    logic commit;    // fold the read fitness into the tournament
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_load;   // current beat is a load
    logic draw_ok;   // current beat is a draw of a fresh, in-range index
    logic done;      // pending draw completes the tournament
    logic out_stall; // result register full and not being taken
  } sts_t;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CMP  = 2'b10
  } state_e;

endpackage

FILE: hdl/tps_if.sv
// Valid/ready channel interfaces for input items and results.
// Depends on tps_pkg for the payload types.
interface tps_item_if;
  logic          valid;
  logic          ready;
  tps_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tps_result_if;
  logic            valid;
  logic            ready;
  tps_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/tps_ctrl.sv
// Controller for the tournament parent selector: accepts beats and
// sequences each draw through table read and compare. Depends on tps_pkg.
module tps_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tps_pkg::sts_t sts_i,
  output tps_pkg::cmd_t cmd_o
);
  import tps_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  // Beats are taken only while idle
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o.load_we = 1'b0;
    cmd_o.draw_go = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load_we = accept && sts_i.is_load;
        cmd_o.draw_go = accept && sts_i.draw_ok;
        if (accept && sts_i.draw_ok) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        // hold while a finishing draw has nowhere to put its result
        if (!(sts_i.done && sts_i.out_stall)) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Checks
  a_commit_in_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> state_q == ST_CMP)
    else $error("commit outside compare state");

  a_draw_to_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.draw_go |=> state_q == ST_CMP)
    else $error("accepted draw did not enter compare");

  a_no_double_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load_we && cmd_o.draw_go))
    else $error("load and draw issued together");

endmodule

FILE: hdl/tps_dpath.sv
// Datapath for the tournament parent selector: configuration registers,
// fitness table, seen bits, running best and result register. Uses tps_pkg.
module tps_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tps_pkg::CFGA_BITS-1:0]    cfg_idx_i,
  input  logic [tps_pkg::CFG_BITS-1:0]     cfg_data_i,
  input  tps_pkg::item_t                   item_i,
  input  tps_pkg::cmd_t                    cmd_i,
  output tps_pkg::sts_t                    sts_o,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output tps_pkg::result_t                 res_o
);
  import tps_pkg::*;

  logic [CFG_BITS-1:0] pop_q, tsize_q;
  logic [CNT_BITS-1:0] eff_pop, tsize_min1, eff_size;

  logic [FIT_BITS-1:0] fit_mem_q [MAX_POP];
  logic [FIT_BITS-1:0] rd_q;
  logic [IDX_BITS-1:0] idx_q;

  logic [MAX_POP-1:0]  seen_q;
  logic [CNT_BITS-1:0] cnt_q, cnt_nx;
  logic [FIT_BITS-1:0] lead_fit_q, nb_fit;
  logic [IDX_BITS-1:0] best_idx_q, nb_idx;
  logic                best_found_q, nb_found;
  logic                better, finish;

  logic    res_valid_q;
  result_t res_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_q   <= CFG_BITS'(MAX_POP);
      tsize_q <= CFG_BITS'(2);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POPULATION: pop_q   <= cfg_data_i;
        CFG_TOURN_SIZE: tsize_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective population and tournament size (clamped)
  always_comb begin
    if (pop_q == '0) begin
      eff_pop = CNT_BITS'(1);
    end else if (CNT_BITS'(pop_q) > CNT_BITS'(MAX_POP)) begin
      eff_pop = CNT_BITS'(MAX_POP);
    end else begin
      eff_pop = CNT_BITS'(pop_q);
    end
    tsize_min1 = (tsize_q == '0) ? CNT_BITS'(1) : CNT_BITS'(tsize_q);
    eff_size   = (tsize_min1 > eff_pop) ? eff_pop : tsize_min1;
  end

  // Fitness table: one write or one read per cycle, registered read data
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      fit_mem_q[item_i.entry_index] <= item_i.fitness_value;
    end
    if (cmd_i.draw_go) begin
      rd_q  <= fit_mem_q[item_i.entry_index];
      idx_q <= item_i.entry_index;
    end
  end

  // Status for the controller
  assign sts_o.is_load   = (item_i.mode == MODE_LOAD);
  assign sts_o.draw_ok   = (item_i.mode == MODE_DRAW)
                        && (CNT_BITS'(item_i.entry_index) < eff_pop)
                        && !seen_q[item_i.entry_index];
  assign sts_o.done      = finish;
  assign sts_o.out_stall = res_valid_q && !res_ready_i;

  // Compare the read fitness against the running best
  always_comb begin
    better   = (rd_q > lead_fit_q);
    nb_fit   = better ? rd_q  : lead_fit_q;
    nb_idx   = better ? idx_q : best_idx_q;
    nb_found = better || best_found_q;
    cnt_nx   = cnt_q + CNT_BITS'(1);
    finish   = (cnt_nx >= eff_size);
  end

  // Tournament state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= '0;
      cnt_q        <= '0;
      lead_fit_q   <= '0;
      best_idx_q   <= '0;
      best_found_q <= 1'b0;
    end else if (cmd_i.draw_go) begin
      seen_q[item_i.entry_index] <= 1'b1;
    end else if (cmd_i.commit) begin
      if (finish) begin
        seen_q       <= '0;
        cnt_q        <= '0;
        lead_fit_q   <= '0;
        best_idx_q   <= '0;
        best_found_q <= 1'b0;
      end else begin
        cnt_q        <= cnt_nx;
        lead_fit_q   <= nb_fit;
        best_idx_q   <= nb_idx;
        best_found_q <= nb_found;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.commit && finish) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && finish) begin
      res_q.winner_index   <= nb_idx;
      res_q.winner_found   <= nb_found;
      res_q.winner_fitness <= nb_fit;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Checks
  a_seen_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.draw_go |=> seen_q[idx_q])
    else $error("drawn index not marked as seen");

  a_clear_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && finish |=> cnt_q == '0 && seen_q == '0 && !best_found_q)
    else $error("tournament state not cleared after result");

  a_found_fitness: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_found_q == (lead_fit_q != '0))
    else $error("found flag disagrees with best fitness");

endmodule

FILE: hdl/tournament_parent_select.sv
// Top level of the tournament parent selector: controller plus datapath.
// Depends on tps_pkg, tps_if (channel interfaces), tps_ctrl and tps_dpath.
//
//   channel    dir  beat payload                                    handshake
//   item_i     in   mode, entry_index, fitness_value                valid/ready
//   result_o   out  winner_index, winner_found, winner_fitness      valid/ready
//   cfg_*_i    in   cfg_idx_i (0 population, 1 tournament), data    we only
//
// A load or an ignored draw is taken while idle; a fresh draw passes accept
// with table read, then compare, since the table read port is registered.
// A result waits in an output register while the next beats are taken; only a
// draw that finishes a tournament while that register is still full stalls.
// Reset sets population 256 and tournament size 2, clears seen bits and best;
// the fitness table is not cleared, so draws must only hit loaded entries.
module tournament_parent_select (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tps_pkg::CFGA_BITS-1:0] cfg_idx_i,
  input  logic [tps_pkg::CFG_BITS-1:0]  cfg_data_i,
  tps_item_if.sink                      item_i,
  tps_result_if.source                  result_o
);
  import tps_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign item_i.ready = in_ready;

  tps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tps_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (result_o.valid),
    .res_ready_i (result_o.ready),
    .res_o       (result_o.data)
  );

endmodule
